@@ src/assert_macros.svh @@
// Assertion macros for the LFU page replacement RTL.
// Needs a clock named clk and an active-high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property, switched off while in reset
`define LFUPR_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("lfu_page_replacement: assertion failed");

// Same-cycle implication
`define LFUPR_ASSERT_IMP(label, ante, cons) \
  `LFUPR_ASSERT(label, (ante) |-> (cons))

// Next-cycle implication
`define LFUPR_ASSERT_NXT(label, ante, cons) \
  `LFUPR_ASSERT(label, (ante) |=> (cons))

`endif

@@ src/lfupr_pkg.sv @@
// Package for the LFU page replacement block: fixed field widths and the
// structs passed between the top level and the frame cells. No dependencies.
`default_nettype none

package lfupr_pkg;

  localparam int PAGE_W      = 8;   // page_number / evicted_page
  localparam int FIU_W       = 5;   // frames_in_use register
  localparam int FRAME_OUT_W = 4;   // frame_index result field
  localparam int TOTAL_W     = 32;  // hit_total / fault_total
  localparam int IN_DATA_W   = 8;
  localparam int OUT_DATA_W  = 80;

  localparam logic [FIU_W-1:0] FIU_RESET = FIU_W'(16);

  // Token flags handed from cell to cell during a scan
  typedef struct packed {
    logic go;     // token present this cycle
    logic found;  // a resident frame already matched the page
    logic have;   // a victim candidate has been picked
  } tok_flags_t;

  // Broadcast from the top level to every cell
  typedef struct packed {
    logic              bump;  // transaction committed: refresh matching counts
    logic [PAGE_W-1:0] page;  // page being referenced
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ src/lfu_page_replacement.sv @@
// LFU page replacement engine: top level with control, totals and output register.
// Depends on lfupr_pkg, lfupr_cell, lfupr_count_mem and assert_macros.svh.
//
// Each page reference (one input transaction) produces one result transaction.
// A new item is taken only once the previous one has committed its result. The
// cycle after acceptance reads the reference count and launches a search token.
// The token then walks the row of frame cells, one cell per cycle, looking for
// the page and picking the least-referenced victim (lowest frame on a tie). When
// the token leaves the last cell the sequencer moves to its update step, which
// commits the result to the output register; the commit waits for as long as an
// earlier result is still held on the output. A new item is accepted while the
// previous result still waits on the output. After reset the block takes no item
// while the reference count memory is cleared; writes to frames_in_use are taken
// at any time but should only be made while idle.
`default_nettype none
`include "assert_macros.svh"

module lfu_page_replacement
  import lfupr_pkg::*;
#(
  parameter int NUM_FRAMES    = 16,
  parameter int PAGE_ID_COUNT = 256,
  parameter int COUNT_WIDTH   = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // configuration: frames_in_use
  input  wire logic                  cfg_wr_en,
  input  wire logic [FIU_W-1:0]      cfg_wr_data,
  // page references
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,   // [7:0] page_number
  // results
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata    // [0] hit, [4:1] frame_index,
                                                // [5] evicted_valid,
                                                // [13:6] evicted_page,
                                                // [45:14] hit_total,
                                                // [77:46] fault_total, [79:78] 0
);

  localparam int FW  = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int FCW = $clog2(NUM_FRAMES + 1);
  localparam int SW  = $clog2(PAGE_ID_COUNT);
  localparam int CW  = COUNT_WIDTH;
  localparam int LUT_DEPTH = 1 << PAGE_W;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_UPDATE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  logic [FIU_W-1:0]  frames_in_use;
  logic [FCW-1:0]    eff_frames;
  logic [FCW-1:0]    filled;
  logic [TOTAL_W-1:0] hits;
  logic [TOTAL_W-1:0] faults;

  logic              accept;
  logic              start;
  logic              commit;
  logic [PAGE_W-1:0] page;
  logic [SW-1:0]     slot;
  logic [SW-1:0]     in_slot;
  logic [CW-1:0]     rd_cnt;
  logic [CW-1:0]     new_cnt;
  logic              mem_ready;

  logic [SW-1:0]     slot_lut [LUT_DEPTH];

  cell_ctl_t         ctl;
  logic [NUM_FRAMES-1:0] load_en;
  logic [FW-1:0]     load_where;
  logic              fill_free;

  tok_flags_t        flg       [NUM_FRAMES];
  logic [FW-1:0]     wh        [NUM_FRAMES];
  logic [FW-1:0]     bidx      [NUM_FRAMES];
  logic [CW-1:0]     bcnt      [NUM_FRAMES];
  logic [PAGE_W-1:0] bpage     [NUM_FRAMES];
  tok_flags_t        seed_flags;

  logic                   o_hit;
  logic [FRAME_OUT_W-1:0] o_frame;
  logic                   o_ev_valid;
  logic [PAGE_W-1:0]      o_ev_page;

  // Page number to count slot, worked out at elaboration
  for (genvar v = 0; v < LUT_DEPTH; v++) begin : g_slot_lut
    assign slot_lut[v] = SW'(v % PAGE_ID_COUNT);
  end
  assign in_slot = slot_lut[s_tdata[PAGE_W-1:0]];

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= FIU_RESET;
    end else if (cfg_wr_en) begin
      frames_in_use <= cfg_wr_data;
    end
  end

  // Effective frame count, clamped to 1..NUM_FRAMES
  always_comb begin
    if (frames_in_use == '0) begin
      eff_frames = FCW'(1);
    end else if (int'(frames_in_use) > NUM_FRAMES) begin
      eff_frames = FCW'(NUM_FRAMES);
    end else begin
      eff_frames = FCW'(frames_in_use);
    end
  end

  assign s_tready = (state == S_IDLE) && mem_ready;
  assign accept   = s_tvalid && s_tready;
  assign commit   = (state == S_UPDATE) && (!m_tvalid || m_tready);

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (accept) state_next = S_SCAN;
      S_SCAN:   if (flg[NUM_FRAMES-1].go) state_next = S_UPDATE;
      S_UPDATE: if (commit) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      start <= 1'b0;
    end else begin
      state <= state_next;
      start <= accept;
    end
  end

  // Captured reference
  always_ff @(posedge clk) begin
    if (accept) begin
      page <= s_tdata[PAGE_W-1:0];
      slot <= in_slot;
    end
  end

  lfupr_count_mem #(
    .DEPTH (PAGE_ID_COUNT),
    .SW    (SW),
    .CW    (CW)
  ) u_count_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (in_slot),
    .rd_data (rd_cnt),
    .wr_en   (commit),
    .wr_addr (slot),
    .wr_data (new_cnt),
    .ready   (mem_ready)
  );

  // Saturating reference count after this transaction
  assign new_cnt = (rd_cnt == '1) ? rd_cnt : rd_cnt + CW'(1);

  // Placement: next free frame, else the victim
  assign fill_free  = filled < eff_frames;
  assign load_where = fill_free ? FW'(filled) : bidx[NUM_FRAMES-1];

  assign ctl = '{bump: commit, page: page};

  assign seed_flags = '{go: start, found: 1'b0, have: 1'b0};

  // Row of frame cells
  for (genvar i = 0; i < NUM_FRAMES; i++) begin : g_cell
    assign load_en[i] = commit && !flg[NUM_FRAMES-1].found && (load_where == FW'(i));

    if (i == 0) begin : g_head
      lfupr_cell #(
        .IDX (i), .FW (FW), .FCW (FCW), .SW (SW), .CW (CW)
      ) u_cell (
        .clk           (clk),
        .rst           (rst),
        .ctl           (ctl),
        .load          (load_en[i]),
        .slot          (slot),
        .new_cnt       (new_cnt),
        .filled        (filled),
        .eff_frames    (eff_frames),
        .flags_in      (seed_flags),
        .where_in      ('0),
        .best_idx_in   ('0),
        .best_cnt_in   ('0),
        .best_page_in  ('0),
        .flags_out     (flg[i]),
        .where_out     (wh[i]),
        .best_idx_out  (bidx[i]),
        .best_cnt_out  (bcnt[i]),
        .best_page_out (bpage[i])
      );
    end else begin : g_body
      lfupr_cell #(
        .IDX (i), .FW (FW), .FCW (FCW), .SW (SW), .CW (CW)
      ) u_cell (
        .clk           (clk),
        .rst           (rst),
        .ctl           (ctl),
        .load          (load_en[i]),
        .slot          (slot),
        .new_cnt       (new_cnt),
        .filled        (filled),
        .eff_frames    (eff_frames),
        .flags_in      (flg[i-1]),
        .where_in      (wh[i-1]),
        .best_idx_in   (bidx[i-1]),
        .best_cnt_in   (bcnt[i-1]),
        .best_page_in  (bpage[i-1]),
        .flags_out     (flg[i]),
        .where_out     (wh[i]),
        .best_idx_out  (bidx[i]),
        .best_cnt_out  (bcnt[i]),
        .best_page_out (bpage[i])
      );
    end
  end

  // Fill count and running totals
  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
      hits   <= '0;
      faults <= '0;
    end else if (commit) begin
      if (flg[NUM_FRAMES-1].found) begin
        if (hits != '1) hits <= hits + TOTAL_W'(1);
      end else begin
        if (faults != '1) faults <= faults + TOTAL_W'(1);
        if (fill_free) filled <= filled + FCW'(1);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      o_hit <= flg[NUM_FRAMES-1].found;
      if (flg[NUM_FRAMES-1].found) begin
        o_frame    <= FRAME_OUT_W'(wh[NUM_FRAMES-1]);
        o_ev_valid <= 1'b0;
        o_ev_page  <= '0;
      end else begin
        o_frame    <= FRAME_OUT_W'(load_where);
        o_ev_valid <= !fill_free;
        o_ev_page  <= fill_free ? '0 : bpage[NUM_FRAMES-1];
      end
    end
  end

  assign m_tdata = {2'b00, faults, hits, o_ev_page, o_ev_valid, o_frame, o_hit};

  // Checks
  `LFUPR_ASSERT_NXT(a_accept_starts_scan, accept, (state == S_SCAN) && start)
  `LFUPR_ASSERT_IMP(a_token_ends_in_scan, flg[NUM_FRAMES-1].go, state == S_SCAN)
  `LFUPR_ASSERT(a_fill_bound, filled <= FCW'(NUM_FRAMES))
  `LFUPR_ASSERT_NXT(a_update_waits, (state == S_UPDATE) && m_tvalid && !m_tready,
                    state == S_UPDATE)

endmodule

`default_nettype wire

@@ src/lfupr_cell.sv @@
// One frame cell: holds a resident page, its count slot and a copy of its
// reference count, and passes the search token on. Depends on lfupr_pkg.
`default_nettype none

module lfupr_cell
  import lfupr_pkg::*;
#(
  parameter int IDX = 0,
  parameter int FW  = 4,
  parameter int FCW = 5,
  parameter int SW  = 8,
  parameter int CW  = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cell_ctl_t         ctl,
  input  wire logic              load,
  input  wire logic [SW-1:0]     slot,
  input  wire logic [CW-1:0]     new_cnt,
  input  wire logic [FCW-1:0]    filled,
  input  wire logic [FCW-1:0]    eff_frames,
  input  wire tok_flags_t        flags_in,
  input  wire logic [FW-1:0]     where_in,
  input  wire logic [FW-1:0]     best_idx_in,
  input  wire logic [CW-1:0]     best_cnt_in,
  input  wire logic [PAGE_W-1:0] best_page_in,
  output tok_flags_t             flags_out,
  output logic [FW-1:0]          where_out,
  output logic [FW-1:0]          best_idx_out,
  output logic [CW-1:0]          best_cnt_out,
  output logic [PAGE_W-1:0]      best_page_out
);

  logic [PAGE_W-1:0] page;
  logic [SW-1:0]     page_slot;
  logic [CW-1:0]     cnt;

  logic go;
  logic found;
  logic have;

  logic hit_here;
  logic victim_here;

  // Frame contents: loaded on a fill or eviction, count refreshed on a
  // reference to any page sharing the slot
  always_ff @(posedge clk) begin
    if (load) begin
      page      <= ctl.page;
      page_slot <= slot;
      cnt       <= new_cnt;
    end else if (ctl.bump && (page_slot == slot)) begin
      cnt <= new_cnt;
    end
  end

  // Local match and victim test
  assign hit_here    = (FCW'(IDX) < filled) && (page == ctl.page);
  assign victim_here = (FCW'(IDX) < eff_frames) &&
                       (!flags_in.have || (cnt < best_cnt_in));

  // Token flag
  always_ff @(posedge clk) begin
    if (rst) begin
      go <= 1'b0;
    end else begin
      go <= flags_in.go;
    end
  end

  // Token payload, held until the next token arrives
  always_ff @(posedge clk) begin
    if (flags_in.go) begin
      found <= flags_in.found || hit_here;
      have  <= flags_in.have || victim_here;
      if (!flags_in.found && hit_here) begin
        where_out <= FW'(IDX);
      end else begin
        where_out <= where_in;
      end
      if (victim_here) begin
        best_idx_out  <= FW'(IDX);
        best_cnt_out  <= cnt;
        best_page_out <= page;
      end else begin
        best_idx_out  <= best_idx_in;
        best_cnt_out  <= best_cnt_in;
        best_page_out <= best_page_in;
      end
    end
  end

  assign flags_out = '{go: go, found: found, have: have};

endmodule

`default_nettype wire

@@ src/lfupr_count_mem.sv @@
// Per-page reference count memory with a clearing pass after reset.
// One write and one registered read port. Depends on lfupr_pkg.
`default_nettype none

module lfupr_count_mem
  import lfupr_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int SW    = 8,
  parameter int CW    = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          rd_en,
  input  wire logic [SW-1:0] rd_addr,
  output logic [CW-1:0]      rd_data,
  input  wire logic          wr_en,
  input  wire logic [SW-1:0] wr_addr,
  input  wire logic [CW-1:0] wr_data,
  output logic               ready
);

  logic [CW-1:0] mem [DEPTH];

  logic          clearing;
  logic [SW-1:0] clear_ptr;

  // Clearing pass: one entry a cycle from reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clear_ptr <= '0;
    end else if (clearing) begin
      clear_ptr <= clear_ptr + SW'(1);
      if (clear_ptr == SW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Write port
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clear_ptr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign ready = !clearing;

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// Self-checking testbench for lfu_page_replacement: streams page references, predicts
// hit/miss, frame, victim and totals in step, and compares every result transaction.
// Depends on lfupr_pkg and the RTL of lfu_page_replacement.
`default_nettype none

module testbench;
  import lfupr_pkg::*;

  localparam int FRAME_SLOTS = 16;
  localparam int STALL_LIMIT = 4000;
  localparam int PAD_W       = OUT_DATA_W - 2 - FRAME_OUT_W - PAGE_W - 2 * TOTAL_W;

  // Result fields, lowest bit last
  typedef struct packed {
    logic [PAD_W-1:0]       pad;
    logic [TOTAL_W-1:0]     fault_total;
    logic [TOTAL_W-1:0]     hit_total;
    logic [PAGE_W-1:0]      evicted_page;
    logic                   evicted_valid;
    logic [FRAME_OUT_W-1:0] frame_index;
    logic                   hit;
  } lookup_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [FIU_W-1:0]      cfg_wr_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // [7:0] page_number
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // hit, frame_index, evicted_valid,
                                         // evicted_page, hit_total, fault_total

  // Pages waiting to be sent, and lookups still owed by the block
  logic [PAGE_W-1:0] page_refs_q[$];
  lookup_result_t    lookups_due_q[$];

  // Predicted engine state
  logic [PAGE_W-1:0]  resident_page[FRAME_SLOTS] = '{default: '0};
  int                 slots_filled = 0;
  logic [15:0]        ref_count[256] = '{default: '0};
  logic [TOTAL_W-1:0] hit_count = '0;
  logic [TOTAL_W-1:0] fault_count = '0;
  logic [FIU_W-1:0]   frames_reg = FIU_RESET;

  int  errors = 0;
  int  stall_cycles = 0;
  bit  ref_taken = 1'b0;
  // both sides open with a calm stretch
  int  send_calm = 120, send_hold = 0, recv_calm = 1000;

  lfu_page_replacement i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Effective frame count, clamped to 1..FRAME_SLOTS
  function automatic int frames_allowed(input logic [FIU_W-1:0] v);
    if (v == 0) return 1;
    if (v > FRAME_SLOTS) return FRAME_SLOTS;
    return int'(v);
  endfunction

  // Look one page up, update the LFU state and return the expected result
  function automatic lookup_result_t resolve_reference(input logic [PAGE_W-1:0] page);
    lookup_result_t r;
    int             limit;
    int             filled;
    int             slot;
    int             best;
    logic [15:0]    best_cnt;
    bit             found;
    r      = '0;
    limit  = frames_allowed(frames_reg);
    filled = (slots_filled > FRAME_SLOTS) ? FRAME_SLOTS : slots_filled;
    found  = 1'b0;
    slot   = 0;
    for (int j = 0; j < filled; j++) begin
      if (!found && resident_page[j] == page) begin
        found = 1'b1;
        slot  = j;
      end
    end
    if (found) begin
      if (hit_count != '1) hit_count++;
    end else begin
      if (fault_count != '1) fault_count++;
      if (filled < limit) begin
        slot = filled;
        resident_page[slot] = page;
        slots_filled = filled + 1;
      end else begin
        // least referenced among the allowed frames, lowest index on a tie
        best     = 0;
        best_cnt = ref_count[resident_page[0]];
        for (int j = 1; j < limit; j++) begin
          if (ref_count[resident_page[j]] < best_cnt) begin
            best_cnt = ref_count[resident_page[j]];
            best     = j;
          end
        end
        slot            = best;
        r.evicted_valid = 1'b1;
        r.evicted_page  = resident_page[best];
        resident_page[best] = page;
      end
    end
    if (ref_count[page] != 16'hFFFF) ref_count[page]++;
    r.hit         = found;
    r.frame_index = slot[FRAME_OUT_W-1:0];
    r.hit_total   = hit_count;
    r.fault_total = fault_count;
    return r;
  endfunction

  function automatic void report_field(input string name, input logic [63:0] exp_v,
                                       input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Idle roll: about a quarter of cycles, with occasional calm stretches
  function automatic bit pause_now(inout int calm);
    if (calm > 0) begin
      calm--;
      return 1'b0;
    end
    if ($urandom_range(0, 299) == 0) begin
      calm = $urandom_range(100, 250);
      return 1'b0;
    end
    return $urandom_range(0, 99) < 25;
  endfunction

  // Monitor: register writes, accepted references and result checks
  always @(posedge clk) begin
    lookup_result_t got;
    lookup_result_t want;
    ref_taken = !rst && s_tvalid && s_tready;
    if (!rst && cfg_wr_en) frames_reg = cfg_wr_data;
    if (ref_taken) lookups_due_q.push_back(resolve_reference(s_tdata[PAGE_W-1:0]));
    if (!rst && m_tvalid && m_tready) begin
      got = lookup_result_t'(m_tdata);
      if (lookups_due_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %0h", $time, m_tdata);
        errors++;
      end else begin
        want = lookups_due_q.pop_front();
        report_field("hit", 64'(want.hit), 64'(got.hit));
        report_field("frame_index", 64'(want.frame_index), 64'(got.frame_index));
        report_field("evicted_valid", 64'(want.evicted_valid), 64'(got.evicted_valid));
        report_field("evicted_page", 64'(want.evicted_page), 64'(got.evicted_page));
        report_field("hit_total", 64'(want.hit_total), 64'(got.hit_total));
        report_field("fault_total", 64'(want.fault_total), 64'(got.fault_total));
        report_field("padding", 64'(want.pad), 64'(got.pad));
      end
    end
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (!rst && ((s_tvalid && s_tready) || (m_tvalid && m_tready))) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Reference driver: holds an item until taken, then loads the next
  always @(negedge clk) begin
    if (!rst && (!s_tvalid || ref_taken)) begin
      if (send_hold > 0) begin
        send_hold <= send_hold - 1;
        s_tvalid  <= 1'b0;
      end else if (page_refs_q.size() != 0 && !pause_now(send_calm)) begin
        s_tvalid <= 1'b1;
        s_tdata  <= page_refs_q.pop_front();
      end else begin
        s_tvalid <= 1'b0;
        if ($urandom_range(0, 15) == 0) send_hold <= $urandom_range(5, 30);
      end
    end
  end

  // Result sink back-pressure
  always @(negedge clk) begin
    m_tready <= !rst && !pause_now(recv_calm);
  end

  task automatic wait_quiet();
    do @(negedge clk);
    while (page_refs_q.size() != 0 || s_tvalid || lookups_due_q.size() != 0);
  endtask

  task automatic write_frames(input logic [FIU_W-1:0] v);
    wait_quiet();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Random phase: mostly a skewed working set a little larger than the frames
  task automatic random_refs(input logic [FIU_W-1:0] v, input int n);
    logic [PAGE_W-1:0] base;
    int                span;
    int                idx;
    write_frames(v);
    base = PAGE_W'($urandom_range(0, 255));
    span = frames_allowed(v) + $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 80) begin
        idx = ($urandom_range(0, span - 1) * $urandom_range(0, span - 1)) / (span - 1);
        page_refs_q.push_back(base + PAGE_W'(idx));
      end else begin
        page_refs_q.push_back(PAGE_W'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    logic [FIU_W-1:0] frames_plan[8];
    frames_plan = '{5'd16, 5'd1, 5'd2, 5'd4, 5'd17, 5'd8, 5'd0, 5'd12};
    frames_plan[6] = FIU_W'($urandom_range(0, 31));
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // register zero clamps to one frame: extremes of the page field
    write_frames(5'd0);
    page_refs_q = '{8'h00, 8'hFF, 8'hFF, 8'h00};
    // three frames: fill, hit and a least-frequent eviction
    write_frames(5'd3);
    page_refs_q = '{8'h0F, 8'hF0, 8'h0F, 8'hAA, 8'h55};
    // lowered below the filled count: all stay searchable, victims only in frame 0
    write_frames(5'd1);
    page_refs_q = '{8'h0F, 8'hF0, 8'hAA, 8'h33, 8'h33};
    // oversized register clamps to all frames
    write_frames(5'd31);
    page_refs_q = '{8'h80, 8'h81, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87, 8'h33, 8'h88};

    foreach (frames_plan[p]) random_refs(frames_plan[p], 50);

    wait_quiet();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
